/* hw/rtl/rcbf_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rcbf_pkg: shared types and constants for the rounded corner flattener
// Fixed-point formats, register defaults, sequencer states and the control
// word that travels with each curve point through the evaluation pipeline.
// ----------------------------------------------------------------------------
package rcbf_pkg;

  localparam int MAX_SEGMENTS_DEF = 64;
  localparam int COORD_BITS_DEF   = 16;

  localparam int KAPPA_Q16     = 36191;   // 0.552228474 in Q0.16
  localparam int KAPPA_ROUND   = 32768;   // half an LSB of Q0.16
  localparam int T_BITS        = 17;      // t in Q0.16, up to and including 1.0
  localparam int T_ONE         = 65536;
  localparam int W_BITS        = 25;      // Bernstein weight in Q0.24, up to 1.0
  localparam int W_ROUND       = 8388608; // half an LSB of Q0.24
  localparam int SEG_BITS      = 7;
  localparam int STEP_BITS     = 16;
  localparam int CFG_DATA_BITS = 16;
  localparam int SEGMENTS_RST  = 6;
  localparam int T_STEP_RST    = 10923;
  localparam int CP_NUM        = 8;       // P1, C1, C2, P3 as x then y

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PROD,
    ST_CTRL,
    ST_RUN
  } seq_state_t;

  typedef enum logic {
    CFG_SEGMENTS = 1'b0,
    CFG_T_STEP   = 1'b1
  } cfg_index_t;

  typedef struct packed {
    logic valid;
    logic last;
  } pt_ctl_t;

endpackage : rcbf_pkg
`default_nettype wire

/* hw/rtl/rounded_corner_bezier_flattener.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rounded_corner_bezier_flattener: outline vertex generator
// Turns line starts and rounded corners into a stream of outline vertices.
// ----------------------------------------------------------------------------
// A line start (mode 0) yields its start point as one vertex with last set.
// A corner (mode 1) with start P1, apex P2 and end P3 yields segments-1
// points of the cubic with control points C1 = P1 + kappa*(P3-P2) and
// C2 = P3 + kappa*(P1-P2), at t = 0, t_step, 2*t_step, ... (t held at 1.0),
// the final one flagged with last. Coordinates are signed Q11.4, t_step is
// Q0.16, results are rounded to nearest and saturated. The sequencer takes
// one transaction at a time: a corner goes through capture, kappa multiply
// and control point add, with segments first clamped into [2, MAX_SEGMENTS],
// then issues one point per cycle while the output is not stalled; a line
// start goes from capture straight to issuing its single point. Points flow
// through a four-stage evaluation pipeline (u/t squares, cubic weights,
// weight products, sum and round) whose last stage is the output register.
// Output backpressure stalls the whole pipeline and the point issue of the
// sequencer; the capture, kappa multiply and control point add steps do not
// wait for it. Write segments and t_step only while the block is idle.
// ----------------------------------------------------------------------------
module rounded_corner_bezier_flattener #(
  parameter int MAX_SEGMENTS = rcbf_pkg::MAX_SEGMENTS_DEF,
  parameter int COORD_BITS   = rcbf_pkg::COORD_BITS_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  // item transaction
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire logic                                 mode,
  input  wire logic signed [COORD_BITS-1:0]         start_x,
  input  wire logic signed [COORD_BITS-1:0]         start_y,
  input  wire logic signed [COORD_BITS-1:0]         corner_x,
  input  wire logic signed [COORD_BITS-1:0]         corner_y,
  input  wire logic signed [COORD_BITS-1:0]         end_x,
  input  wire logic signed [COORD_BITS-1:0]         end_y,
  // vertex transaction
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output logic signed [COORD_BITS-1:0]              vertex_x,
  output logic signed [COORD_BITS-1:0]              vertex_y,
  output logic                                      last,
  // register writes
  input  wire logic                                 cfg_we,
  input  wire rcbf_pkg::cfg_index_t                 cfg_index,
  input  wire logic [rcbf_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
  import rcbf_pkg::*;

  logic [SEG_BITS-1:0]  segments;
  logic [STEP_BITS-1:0] t_step;

  // Configuration registers; a write takes effect in the following cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      segments <= SEG_BITS'(SEGMENTS_RST);
      t_step   <= STEP_BITS'(T_STEP_RST);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SEGMENTS: segments <= cfg_data[SEG_BITS-1:0];
        CFG_T_STEP:   t_step   <= cfg_data[STEP_BITS-1:0];
        default: ;
      endcase
    end
  end

  pt_ctl_t                      seq_ctl, wgt_ctl, out_ctl;
  logic [T_BITS-1:0]            seq_t;
  logic signed [COORD_BITS-1:0] seq_cp [CP_NUM];
  logic [W_BITS-1:0]            wgt_w [4];
  logic signed [COORD_BITS-1:0] wgt_cp [CP_NUM];
  logic                         adv;

  // Advance every stage unless the output register holds a vertex that is
  // not being taken this cycle; hold everything otherwise.
  assign adv = !out_ctl.valid || out_ready;

  rcbf_seq #(
    .MAX_SEGMENTS (MAX_SEGMENTS),
    .COORD_BITS   (COORD_BITS)
  ) u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .mode     (mode),
    .start_x  (start_x),
    .start_y  (start_y),
    .corner_x (corner_x),
    .corner_y (corner_y),
    .end_x    (end_x),
    .end_y    (end_y),
    .segments (segments),
    .t_step   (t_step),
    .adv      (adv),
    .pt_ctl   (seq_ctl),
    .pt_t     (seq_t),
    .pt_cp    (seq_cp)
  );

  rcbf_weights #(
    .COORD_BITS (COORD_BITS)
  ) u_weights (
    .clk     (clk),
    .rst     (rst),
    .adv     (adv),
    .in_ctl  (seq_ctl),
    .in_t    (seq_t),
    .in_cp   (seq_cp),
    .out_ctl (wgt_ctl),
    .out_w   (wgt_w),
    .out_cp  (wgt_cp)
  );

  rcbf_blend #(
    .COORD_BITS (COORD_BITS)
  ) u_blend (
    .clk     (clk),
    .rst     (rst),
    .adv     (adv),
    .in_ctl  (wgt_ctl),
    .in_w    (wgt_w),
    .in_cp   (wgt_cp),
    .out_ctl (out_ctl),
    .out_x   (vertex_x),
    .out_y   (vertex_y)
  );

  assign out_valid = out_ctl.valid;
  assign last      = out_ctl.last;

endmodule : rounded_corner_bezier_flattener
`default_nettype wire

/* hw/rtl/rcbf_seq.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rcbf_seq: item sequencer
// Captures one transaction, builds the control points and issues one curve
// point (t plus control points) per cycle while adv is high into the evaluation pipeline.
// ----------------------------------------------------------------------------
module rcbf_seq #(
  parameter int MAX_SEGMENTS = rcbf_pkg::MAX_SEGMENTS_DEF,
  parameter int COORD_BITS   = rcbf_pkg::COORD_BITS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic                                mode,
  input  wire logic signed [COORD_BITS-1:0]        start_x,
  input  wire logic signed [COORD_BITS-1:0]        start_y,
  input  wire logic signed [COORD_BITS-1:0]        corner_x,
  input  wire logic signed [COORD_BITS-1:0]        corner_y,
  input  wire logic signed [COORD_BITS-1:0]        end_x,
  input  wire logic signed [COORD_BITS-1:0]        end_y,
  input  wire logic [rcbf_pkg::SEG_BITS-1:0]       segments,
  input  wire logic [rcbf_pkg::STEP_BITS-1:0]      t_step,
  input  wire logic                                adv,
  output rcbf_pkg::pt_ctl_t                        pt_ctl,
  output logic [rcbf_pkg::T_BITS-1:0]              pt_t,
  output logic signed [COORD_BITS-1:0]             pt_cp [rcbf_pkg::CP_NUM]
);
  import rcbf_pkg::*;

  localparam int CNT_W = (MAX_SEGMENTS > 2) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int PW    = COORD_BITS + 18;
  localparam int SW    = COORD_BITS + 2;

  function automatic logic signed [COORD_BITS-1:0] sat_c(input logic signed [SW-1:0] v);
    logic signed [SW-1:0] hi;
    logic signed [SW-1:0] lo;
    hi = SW'($signed({1'b0, {(COORD_BITS-1){1'b1}}}));
    lo = -hi - SW'(1);
    if (v > hi) begin
      return COORD_BITS'(hi);
    end else if (v < lo) begin
      return COORD_BITS'(lo);
    end
    return COORD_BITS'(v);
  endfunction

  seq_state_t state, state_next;

  logic signed [COORD_BITS-1:0] p1x, p1y, p2x, p2y, p3x, p3y;
  logic signed [COORD_BITS-1:0] cp [CP_NUM];
  logic signed [PW-1:0]         prod [4];
  logic [CNT_W-1:0]             rem;
  logic [T_BITS-1:0]            t;

  logic [8:0]                   seg9, seg_clamp;
  logic [CNT_W-1:0]             rem_init;
  logic [T_BITS:0]              t_sum;
  logic signed [COORD_BITS:0]   diff [4];
  logic signed [COORD_BITS-1:0] base [4];
  logic signed [COORD_BITS-1:0] ctrl [4];
  logic signed [PW-1:0]         rnd;
  logic signed [SW-1:0]         ctrl_sum;

  // Clamp segments into [2, MAX_SEGMENTS]; a corner emits segments-1 points.
  always_comb begin
    seg9 = 9'(segments);
    if (seg9 < 9'd2) begin
      seg_clamp = 9'd2;
    end else if (seg9 > 9'(MAX_SEGMENTS)) begin
      seg_clamp = 9'(MAX_SEGMENTS);
    end else begin
      seg_clamp = seg9;
    end
    rem_init = CNT_W'(seg_clamp - 9'd2);
    t_sum    = (T_BITS+1)'(t) + (T_BITS+1)'(t_step);
  end

  // C1 = P1 + kappa*(P3-P2), C2 = P3 + kappa*(P1-P2)
  always_comb begin
    diff[0] = (COORD_BITS+1)'(p3x) - (COORD_BITS+1)'(p2x);
    diff[1] = (COORD_BITS+1)'(p3y) - (COORD_BITS+1)'(p2y);
    diff[2] = (COORD_BITS+1)'(p1x) - (COORD_BITS+1)'(p2x);
    diff[3] = (COORD_BITS+1)'(p1y) - (COORD_BITS+1)'(p2y);
    base[0] = p1x;
    base[1] = p1y;
    base[2] = p3x;
    base[3] = p3y;
    for (int k = 0; k < 4; k++) begin
      rnd      = prod[k] + PW'(KAPPA_ROUND);
      ctrl_sum = SW'(base[k]) + SW'(rnd >>> 16);
      ctrl[k]  = sat_c(ctrl_sum);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = mode ? ST_PROD : ST_RUN;
        end
      end
      ST_PROD: state_next = ST_CTRL;
      ST_CTRL: state_next = ST_RUN;
      ST_RUN: begin
        if (adv && rem == '0) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready     = 1'b0;
    pt_ctl.valid = 1'b0;
    unique case (state)
      ST_IDLE: in_ready     = 1'b1;
      ST_RUN:  pt_ctl.valid = 1'b1;
      default: ;
    endcase
    pt_ctl.last = (rem == '0);
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          p1x <= start_x;
          p1y <= start_y;
          p2x <= corner_x;
          p2y <= corner_y;
          p3x <= end_x;
          p3y <= end_y;
          // A line start evaluates at t = 0 with every point at P1.
          for (int k = 0; k < CP_NUM - 2; k += 2) begin
            cp[k]   <= start_x;
            cp[k+1] <= start_y;
          end
          cp[6] <= mode ? end_x : start_x;
          cp[7] <= mode ? end_y : start_y;
          rem <= mode ? rem_init : '0;
          t   <= '0;
        end
      end
      ST_PROD: begin
        for (int k = 0; k < 4; k++) begin
          prod[k] <= PW'(diff[k]) * PW'(KAPPA_Q16);
        end
      end
      ST_CTRL: begin
        for (int k = 0; k < 4; k++) begin
          cp[k+2] <= ctrl[k];
        end
      end
      ST_RUN: begin
        if (adv) begin
          rem <= rem - CNT_W'(1);
          t   <= (t_sum > (T_BITS+1)'(T_ONE)) ? T_BITS'(T_ONE) : T_BITS'(t_sum);
        end
      end
      default: ;
    endcase
  end

  assign pt_t  = t;
  assign pt_cp = cp;

endmodule : rcbf_seq
`default_nettype wire

/* hw/rtl/rcbf_weights.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rcbf_weights: Bernstein weight stages
// Two register stages: partial squares of u and t, then the four cubic
// weights in Q0.24, with the t^3 weight taken so that they sum to one.
// ----------------------------------------------------------------------------
module rcbf_weights #(
  parameter int COORD_BITS = rcbf_pkg::COORD_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              adv,
  input  wire rcbf_pkg::pt_ctl_t                 in_ctl,
  input  wire logic [rcbf_pkg::T_BITS-1:0]       in_t,
  input  wire logic signed [COORD_BITS-1:0]      in_cp [rcbf_pkg::CP_NUM],
  output rcbf_pkg::pt_ctl_t                      out_ctl,
  output logic [rcbf_pkg::W_BITS-1:0]            out_w [4],
  output logic signed [COORD_BITS-1:0]           out_cp [rcbf_pkg::CP_NUM]
);
  import rcbf_pkg::*;

  pt_ctl_t                      ctl1, ctl2;
  logic [T_BITS-1:0]            u1, t1;
  logic [2*T_BITS-1:0]          uu1, ut1;
  logic signed [COORD_BITS-1:0] cp1 [CP_NUM];
  logic signed [COORD_BITS-1:0] cp2 [CP_NUM];
  logic [W_BITS-1:0]            w2 [4];

  logic [T_BITS-1:0] u_c;
  logic [50:0]       f0, f1p, f2p;
  logic [52:0]       f1, f2;
  logic [W_BITS-1:0] w_c [4];

  assign u_c = T_BITS'(T_ONE) - in_t;

  always_comb begin
    f0  = 51'(uu1) * 51'(u1);
    f1p = 51'(uu1) * 51'(t1);
    f2p = 51'(ut1) * 51'(t1);
    f1  = 53'(f1p) + 53'({f1p, 1'b0});
    f2  = 53'(f2p) + 53'({f2p, 1'b0});
    w_c[0] = f0[48:24];
    w_c[1] = f1[48:24];
    w_c[2] = f2[48:24];
    w_c[3] = W_BITS'(1 << 24) - w_c[0] - w_c[1] - w_c[2];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl1 <= '0;
      ctl2 <= '0;
    end else if (adv) begin
      ctl1 <= in_ctl;
      ctl2 <= ctl1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      u1  <= u_c;
      t1  <= in_t;
      uu1 <= (2*T_BITS)'(u_c) * (2*T_BITS)'(u_c);
      ut1 <= (2*T_BITS)'(u_c) * (2*T_BITS)'(in_t);
      cp1 <= in_cp;
      w2  <= w_c;
      cp2 <= cp1;
    end
  end

  assign out_ctl = ctl2;
  assign out_w   = w2;
  assign out_cp  = cp2;

endmodule : rcbf_weights
`default_nettype wire

/* hw/rtl/rcbf_blend.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rcbf_blend: weighted sum and output register
// Multiplies each control point by its weight, then sums, rounds to Q11.4
// and saturates into the output register.
// ----------------------------------------------------------------------------
module rcbf_blend #(
  parameter int COORD_BITS = rcbf_pkg::COORD_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              adv,
  input  wire rcbf_pkg::pt_ctl_t                 in_ctl,
  input  wire logic [rcbf_pkg::W_BITS-1:0]       in_w [4],
  input  wire logic signed [COORD_BITS-1:0]      in_cp [rcbf_pkg::CP_NUM],
  output rcbf_pkg::pt_ctl_t                      out_ctl,
  output logic signed [COORD_BITS-1:0]           out_x,
  output logic signed [COORD_BITS-1:0]           out_y
);
  import rcbf_pkg::*;

  localparam int PRD = COORD_BITS + W_BITS + 1;
  localparam int SW  = PRD + 2;

  function automatic logic signed [COORD_BITS-1:0] sat_w(input logic signed [SW-1:0] v);
    logic signed [SW-1:0] hi;
    logic signed [SW-1:0] lo;
    hi = SW'($signed({1'b0, {(COORD_BITS-1){1'b1}}}));
    lo = -hi - SW'(1);
    if (v > hi) begin
      return COORD_BITS'(hi);
    end else if (v < lo) begin
      return COORD_BITS'(lo);
    end
    return COORD_BITS'(v);
  endfunction

  pt_ctl_t               ctl3, ctl4;
  logic signed [PRD-1:0] prd3 [CP_NUM];
  logic signed [COORD_BITS-1:0] vx, vy;

  logic signed [SW-1:0] sum_x, sum_y;

  always_comb begin
    sum_x = SW'(prd3[0]) + SW'(prd3[2]) + SW'(prd3[4]) + SW'(prd3[6]) + SW'(W_ROUND);
    sum_y = SW'(prd3[1]) + SW'(prd3[3]) + SW'(prd3[5]) + SW'(prd3[7]) + SW'(W_ROUND);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl3 <= '0;
      ctl4 <= '0;
    end else if (adv) begin
      ctl3 <= in_ctl;
      ctl4 <= ctl3;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < CP_NUM; k++) begin
        prd3[k] <= PRD'($signed({1'b0, in_w[k/2]})) * PRD'(in_cp[k]);
      end
      vx <= sat_w(sum_x >>> 24);
      vy <= sat_w(sum_y >>> 24);
    end
  end

  assign out_ctl = ctl4;
  assign out_x   = vx;
  assign out_y   = vy;

endmodule : rcbf_blend
`default_nettype wire
